// ===== design/first_fit_heap_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// first fit heap allocator assertion macros
// shared property forms for the allocator's concurrent checks
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// same-cycle implication, off while reset is high
`define FFA_CHECK(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define FFA_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// shared constants and types of the first fit heap allocator
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

   localparam int HEAP_WORDS_DEF = 4096;
   localparam int WORD_BYTES     = 8;
   localparam int WORD_SHIFT     = $clog2(WORD_BYTES);
   // heap words hold signed byte sizes
   localparam int SZW            = 17;
   localparam int PW             = SZW - WORD_SHIFT;
   localparam int TW             = 16 - WORD_SHIFT;
   localparam int MEM_AW         = 16;

   localparam logic [15:0] HEAP_BYTES_RESET = 16'd32768;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_NOFIT = 2'd1,
      ST_BAD   = 2'd2
   } status_type;

   typedef struct packed {
      logic        opcode;
      logic [15:0] request_bytes;
      logic [15:0] block_offset;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] payload_offset;
   } result_type;

   typedef struct packed {
      logic              wr_en;
      logic [MEM_AW-1:0] wr_addr;
      logic [SZW-1:0]    wr_data;
      logic              rd_en;
      logic [MEM_AW-1:0] rd_addr;
   } mem_req_type;

endpackage

`default_nettype wire

// ===== design/ffa_heap_ram.sv =====
// ----------------------------------------------------------------------------
// ffa_heap_ram
// heap word store: one write port, one read port with registered data
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_heap_ram #(
   parameter int HEAP_WORDS = ffa_pkg::HEAP_WORDS_DEF
) (
   input  wire logic                      clock,
   input  wire ffa_pkg::mem_req_type      mem_req,
   output logic [ffa_pkg::SZW-1:0]        rd_data
);
   import ffa_pkg::*;

   localparam int AW = $clog2(HEAP_WORDS);

   logic [SZW-1:0] store_ff [HEAP_WORDS];
   logic [SZW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         store_ff[mem_req.wr_addr[AW-1:0]] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= store_ff[mem_req.rd_addr[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/ffa_seq.sv =====
// ----------------------------------------------------------------------------
// ffa_seq
// sequencer that walks the boundary tags through one shared address adder
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_fit_heap_allocator_macros.svh"

module ffa_seq #(
   parameter int HEAP_WORDS = ffa_pkg::HEAP_WORDS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               fmt_go,
   input  wire logic                               req_go,
   input  wire ffa_pkg::req_type                   req,
   input  wire logic [$clog2(HEAP_WORDS+1)-1:0]    eff_words,
   output logic                                    idle,
   output logic                                    res_valid,
   input  wire logic                               res_ready,
   output ffa_pkg::result_type                     res,
   output ffa_pkg::mem_req_type                    mem_req,
   input  wire logic [ffa_pkg::SZW-1:0]            rd_data
);
   import ffa_pkg::*;

   localparam int AW = $clog2(HEAP_WORDS);
   localparam int EW = $clog2(HEAP_WORDS + 1);
   localparam int XW = ((EW > SZW) ? EW : SZW) + 2;

   typedef enum logic [12:0] {
      S_IDLE = 13'b0000000000001,
      S_FMT  = 13'b0000000000010,
      S_ARD  = 13'b0000000000100,
      S_ACHK = 13'b0000000001000,
      S_AWR  = 13'b0000000010000,
      S_FRD  = 13'b0000000100000,
      S_FCHK = 13'b0000001000000,
      S_FNX  = 13'b0000010000000,
      S_FNXC = 13'b0000100000000,
      S_FPV  = 13'b0001000000000,
      S_FPVC = 13'b0010000000000,
      S_FWR  = 13'b0100000000000,
      S_RSP  = 13'b1000000000000
   } seq_state_type;

   seq_state_type   state_ff, state_in;
   logic [1:0]      step_ff, step_in;
   logic [AW-1:0]   h_ff, h_in;
   logic [AW-1:0]   start_ff, start_in;
   logic [AW-1:0]   end_ff, end_in;
   logic [TW-1:0]   tgt_ff, tgt_in;
   logic [SZW-1:0]  rq_ff, rq_in;
   logic [SZW-1:0]  sz_ff, sz_in;
   logic [SZW-1:0]  neg_ff, neg_in;
   logic [SZW-1:0]  rem_ff, rem_in;
   logic [PW-1:0]   p_ff, p_in;
   logic            split_ff, split_in;
   result_type      res_ff, res_in;

   logic            rd_zero, rd_neg, rd_pos, rd_fits, rd_split, fchk_walk, fmt_big;
   logic [SZW-1:0]  rd_abs, fmt_size;
   logic [PW-1:0]   rd_words, rq_words;
   logic [XW-1:0]   h_x, eff_x, tgt_x, end_x, words_x, rw_x, p_x;
   logic [XW-1:0]   alu_a, alu_b, alu_sum;

   // decode of the tag word just read
   assign rd_zero  = (rd_data == '0);
   assign rd_neg   = rd_data[SZW-1];
   assign rd_pos   = !rd_neg && !rd_zero;
   assign rd_abs   = rd_neg ? (~rd_data + SZW'(1)) : rd_data;
   assign rd_words = rd_abs[SZW-1:WORD_SHIFT];
   assign rq_words = rq_ff[SZW-1:WORD_SHIFT];
   assign rd_fits  = rd_pos && (rd_data >= rq_ff);
   assign rd_split = {1'b0, rd_data} >= ({1'b0, rq_ff} + (SZW+1)'(2 * WORD_BYTES));

   assign h_x     = XW'(h_ff);
   assign eff_x   = XW'(eff_words);
   assign tgt_x   = XW'(tgt_ff);
   assign end_x   = XW'(end_ff);
   assign words_x = XW'(rd_words);
   assign rw_x    = XW'(rq_words);
   assign p_x     = XW'(p_ff);

   assign fchk_walk = !rd_zero && (h_x < tgt_x);
   assign fmt_big   = eff_x >= XW'(4);
   assign fmt_size  = SZW'((eff_x - XW'(4)) << WORD_SHIFT);

   // operand select of the shared address adder
   always_comb begin
      alu_a = h_x;
      alu_b = '0;
      unique case (state_ff)
         S_FMT: begin
            alu_a = eff_x;
            alu_b = (step_ff == 2'd1) ? ~XW'(1) : '1;
         end
         S_ACHK: begin
            alu_b = words_x + XW'(2);
         end
         S_AWR: begin
            unique case (step_ff)
               2'd0:    alu_b = '0;
               2'd1:    alu_b = split_ff ? (rw_x + XW'(1)) : (p_x + XW'(1));
               2'd2:    alu_b = rw_x + XW'(2);
               default: alu_b = p_x + XW'(1);
            endcase
         end
         S_FCHK: begin
            alu_b = words_x + (fchk_walk ? XW'(2) : XW'(1));
         end
         S_FNX: begin
            alu_a = end_x;
            alu_b = XW'(1);
         end
         S_FNXC: begin
            alu_a = end_x;
            alu_b = words_x + XW'(2);
         end
         S_FPV: begin
            alu_b = '1;
         end
         S_FPVC: begin
            // h minus (previous payload words + 2)
            alu_b = ~(words_x + XW'(1));
         end
         default: begin
            alu_b = '0;
         end
      endcase
   end

   assign alu_sum = alu_a + alu_b;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      h_in     = h_ff;
      start_in = start_ff;
      end_in   = end_ff;
      tgt_in   = tgt_ff;
      rq_in    = rq_ff;
      sz_in    = sz_ff;
      neg_in   = neg_ff;
      rem_in   = rem_ff;
      p_in     = p_ff;
      split_in = split_ff;
      res_in   = res_ff;
      mem_req  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (fmt_go) begin
               state_in = S_FMT;
               step_in  = 2'd0;
            end else if (req_go) begin
               h_in = AW'(1);
               res_in.payload_offset = '0;
               if (req.opcode == OP_ALLOC) begin
                  if (req.request_bytes == '0) begin
                     res_in.status = ST_BAD;
                     state_in      = S_RSP;
                  end else begin
                     rq_in = (SZW'(req.request_bytes) + SZW'(WORD_BYTES - 1))
                             & ~SZW'(WORD_BYTES - 1);
                     state_in = S_ARD;
                  end
               end else begin
                  if (req.block_offset == '0 ||
                      req.block_offset[WORD_SHIFT-1:0] != '0) begin
                     res_in.status = ST_BAD;
                     state_in      = S_RSP;
                  end else begin
                     tgt_in   = TW'(req.block_offset >> WORD_SHIFT) - TW'(1);
                     state_in = S_FRD;
                  end
               end
            end
         end

         S_FMT: begin
            mem_req.wr_en = 1'b1;
            unique case (step_ff)
               2'd0: begin
                  mem_req.wr_addr = MEM_AW'(1);
                  mem_req.wr_data = fmt_big ? fmt_size : '0;
                  if (fmt_big) begin
                     step_in = 2'd1;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
               2'd1: begin
                  mem_req.wr_addr = MEM_AW'(alu_sum);
                  mem_req.wr_data = fmt_size;
                  step_in         = 2'd2;
               end
               default: begin
                  // zero end mark
                  mem_req.wr_addr = MEM_AW'(alu_sum);
                  mem_req.wr_data = '0;
                  state_in        = S_IDLE;
               end
            endcase
         end

         S_ARD: begin
            if (h_x >= eff_x) begin
               res_in.status = ST_NOFIT;
               state_in      = S_RSP;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = MEM_AW'(h_ff);
               state_in        = S_ACHK;
            end
         end

         S_ACHK: begin
            if (rd_zero) begin
               res_in.status = ST_NOFIT;
               state_in      = S_RSP;
            end else if (rd_fits) begin
               split_in = rd_split;
               p_in     = rd_words;
               neg_in   = rd_split ? (SZW'(0) - rq_ff) : (SZW'(0) - rd_data);
               rem_in   = rd_data - rq_ff - SZW'(2 * WORD_BYTES);
               res_in.status         = ST_DONE;
               res_in.payload_offset = 16'((h_x + XW'(1)) << WORD_SHIFT);
               step_in  = 2'd0;
               state_in = S_AWR;
            end else begin
               h_in     = AW'(alu_sum);
               state_in = S_ARD;
            end
         end

         S_AWR: begin
            // header, footer, then the split remainder's header and footer
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = MEM_AW'(alu_sum);
            unique case (step_ff)
               2'd0: begin
                  mem_req.wr_data = neg_ff;
                  step_in         = 2'd1;
               end
               2'd1: begin
                  mem_req.wr_data = neg_ff;
                  if (split_ff) begin
                     step_in = 2'd2;
                  end else begin
                     state_in = S_RSP;
                  end
               end
               2'd2: begin
                  mem_req.wr_data = rem_ff;
                  step_in         = 2'd3;
               end
               default: begin
                  mem_req.wr_data = rem_ff;
                  state_in        = S_RSP;
               end
            endcase
         end

         S_FRD: begin
            if (h_x >= eff_x) begin
               res_in.status = ST_BAD;
               state_in      = S_RSP;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = MEM_AW'(h_ff);
               state_in        = S_FCHK;
            end
         end

         S_FCHK: begin
            if (fchk_walk) begin
               h_in     = AW'(alu_sum);
               state_in = S_FRD;
            end else if (h_x != tgt_x || !rd_neg) begin
               res_in.status = ST_BAD;
               state_in      = S_RSP;
            end else begin
               sz_in    = rd_abs;
               start_in = h_ff;
               end_in   = AW'(alu_sum);
               state_in = S_FNX;
            end
         end

         S_FNX: begin
            if (alu_sum < eff_x) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = MEM_AW'(alu_sum);
               state_in        = S_FNXC;
            end else begin
               state_in = S_FPV;
            end
         end

         S_FNXC: begin
            if (rd_pos) begin
               sz_in  = sz_ff + rd_data + SZW'(2 * WORD_BYTES);
               end_in = AW'(alu_sum);
            end
            state_in = S_FPV;
         end

         S_FPV: begin
            step_in = 2'd0;
            if (h_x > XW'(1)) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = MEM_AW'(alu_sum);
               state_in        = S_FPVC;
            end else begin
               state_in = S_FWR;
            end
         end

         S_FPVC: begin
            // merged block must still start at word 1 or later
            if (rd_pos && !alu_sum[XW-1] && alu_sum != '0) begin
               start_in = AW'(alu_sum);
               sz_in    = sz_ff + rd_data + SZW'(2 * WORD_BYTES);
            end
            state_in = S_FWR;
         end

         S_FWR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_data = sz_ff;
            if (step_ff == 2'd0) begin
               mem_req.wr_addr = MEM_AW'(start_ff);
               step_in         = 2'd1;
            end else begin
               mem_req.wr_addr = MEM_AW'(end_ff);
               res_in.status   = ST_DONE;
               state_in        = S_RSP;
            end
         end

         S_RSP: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_FMT;
         step_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff     <= h_in;
      start_ff <= start_in;
      end_ff   <= end_in;
      tgt_ff   <= tgt_in;
      rq_ff    <= rq_in;
      sz_ff    <= sz_in;
      neg_ff   <= neg_in;
      rem_ff   <= rem_in;
      p_ff     <= p_in;
      split_ff <= split_in;
      res_ff   <= res_in;
   end

   assign idle      = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_RSP);
   assign res       = res_ff;

   `FFA_CHECK_NEXT(a_busy_after_item, clock, reset, req_go && !fmt_go && idle, state_ff != S_IDLE, "item beat taken but sequencer stayed idle")
   `FFA_CHECK(a_used_header, clock, reset, state_ff == S_AWR && step_ff == 2'd0, mem_req.wr_data[SZW-1], "granted block header not marked in use")
   `FFA_CHECK(a_free_tag_positive, clock, reset, state_ff == S_FWR, mem_req.wr_en && !mem_req.wr_data[SZW-1], "freed block tag written negative")
   `FFA_CHECK(a_offset_granted, clock, reset, res_valid && res.payload_offset != '0, res.status == ST_DONE, "nonzero offset on a refused request")

endmodule

`default_nettype wire

// ===== design/first_fit_heap_allocator.sv =====
// allocate and free both walk the tags from word 1; an allocate with a split writes an extra tag pair
// refused items: a bad request, or a walk that ends without a match
// free: the block at word 1 has no previous block to read
// one item at a time; each tag visit is a ram read plus a check
// after reset and after every csr beat a format pass runs before items are taken
// reset is synchronous, active high; heap_bytes returns to 32768
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// first fit allocator over a boundary tag heap held in one word ram
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator #(
   parameter int HEAP_WORDS = ffa_pkg::HEAP_WORDS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_opcode,
   input  wire logic [15:0] req_request_bytes,
   input  wire logic [15:0] req_block_offset,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_payload_offset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_heap_bytes
);
   import ffa_pkg::*;

   localparam int EW = $clog2(HEAP_WORDS + 1);

   logic [15:0]     heap_bytes_ff, heap_bytes_in;
   logic            rsp_valid_ff, rsp_valid_in;
   result_type      rsp_res_ff, rsp_res_in;
   logic [TW-1:0]   hb_words;
   logic [EW-1:0]   eff_words;
   logic            seq_idle, fmt_go, req_go, res_valid, res_ready;
   req_type         req;
   result_type      res;
   mem_req_type     mem_req;
   logic [SZW-1:0]  rd_data;

   assign csr_ready = seq_idle;
   assign req_ready = seq_idle && !csr_valid;
   assign fmt_go    = csr_valid && csr_ready;
   assign req_go    = req_valid && req_ready;

   assign req.opcode        = req_opcode;
   assign req.request_bytes = req_request_bytes;
   assign req.block_offset  = req_block_offset;

   // word count in use, clamped to the ram depth
   assign hb_words  = heap_bytes_ff[15:WORD_SHIFT];
   assign eff_words = (32'(hb_words) >= HEAP_WORDS) ? EW'(HEAP_WORDS) : EW'(hb_words);

   assign heap_bytes_in = fmt_go ? csr_heap_bytes : heap_bytes_ff;

   // output holding register
   assign res_ready    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = (res_valid && res_ready) || (rsp_valid_ff && !rsp_ready);
   assign rsp_res_in   = (res_valid && res_ready) ? res : rsp_res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_bytes_ff <= HEAP_BYTES_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         heap_bytes_ff <= heap_bytes_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_res_ff.status;
   assign rsp_payload_offset = rsp_res_ff.payload_offset;

   ffa_seq #(
      .HEAP_WORDS (HEAP_WORDS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .fmt_go    (fmt_go),
      .req_go    (req_go),
      .req       (req),
      .eff_words (eff_words),
      .idle      (seq_idle),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .mem_req   (mem_req),
      .rd_data   (rd_data)
   );

   ffa_heap_ram #(
      .HEAP_WORDS (HEAP_WORDS)
   ) u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire
